>>> rtl/kalt_pkg.sv
`timescale 1ns / 1ps
package kalt_pkg;

   localparam int STATE_WIDTH_DEF = 32;
   localparam int COV_WIDTH_DEF   = 48;
   localparam int DT_W            = 16;
   localparam int SIGMA_W         = 23;
   localparam int ACCEL_W         = 32;
   localparam int DIST_W          = 31;
   localparam int OUT_W           = 32;
   localparam int OUT_VAR_W       = 47;
   localparam int TERM_W          = 64;
   localparam int PROD_W          = 128;
   localparam int CSR_IDX_W       = 2;
   localparam int PC_W            = 4;

   localparam logic [DT_W-1:0]    DT_RST   = DT_W'(655);
   localparam logic [SIGMA_W-1:0] SIGA_RST = SIGMA_W'(32768);
   localparam logic [SIGMA_W-1:0] SIGL_RST = SIGMA_W'(3277);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SAMPLE_PERIOD = 2'd0,
      CSR_ACCEL_SIGMA   = 2'd1,
      CSR_LIDAR_SIGMA   = 2'd2
   } csr_idx_type;

   typedef enum logic [2:0] {
      SH_NONE, SH_15, SH_16, SH_32, SH_33, SH_49, SH_66
   } shift_type;

   typedef enum logic [3:0] {
      SRC_DT, SRC_DT2, SRC_DT3, SRC_DT4, SRC_QA, SRC_SIGA, SRC_SIGL, SRC_V,
      SRC_AZ, SRC_C, SRC_P11, SRC_P00, SRC_K0, SRC_K1, SRC_Y
   } src_type;

   typedef enum logic [2:0] {
      BASE_ZERO, BASE_H, BASE_V, BASE_P00, BASE_C, BASE_P11
   } base_type;

   typedef enum logic [3:0] {
      DST_DT2, DST_DT3, DST_DT4, DST_QA, DST_H, DST_V, DST_P00, DST_C, DST_P11,
      DST_S, DST_N01, DST_N10
   } dst_type;

   typedef enum logic [2:0] {
      OP_MUL, OP_TEST, OP_DIV_K0, OP_DIV_K1, OP_AVG
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ISSUE, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   typedef struct packed {
      kind_type  kind;
      src_type   a;
      src_type   b;
      logic      inv;
      shift_type shift;
      base_type  base;
      dst_type   dst;
      logic      last;
   } uop_type;

   typedef struct packed {
      logic      start;
      logic      neg;
      shift_type shift;
   } mul_cmd_type;

   function automatic uop_type mk(kind_type k, src_type a, src_type b, logic inv,
                                  shift_type sh, base_type bs, dst_type d, logic last);
      uop_type u;
      u.kind  = k;
      u.a     = a;
      u.b     = b;
      u.inv   = inv;
      u.shift = sh;
      u.base  = bs;
      u.dst   = d;
      u.last  = last;
      return u;
   endfunction

   function automatic uop_type fetch_uop(logic mode, logic [PC_W-1:0] pc);
      uop_type u;
      u = mk(OP_AVG, SRC_DT, SRC_DT, 1'b0, SH_NONE, BASE_ZERO, DST_C, 1'b1);
      if (!mode) begin
         unique case (pc)
            4'd0:  u = mk(OP_MUL, SRC_DT,   SRC_DT,   1'b0, SH_NONE, BASE_ZERO, DST_DT2, 1'b0);
            4'd1:  u = mk(OP_MUL, SRC_DT2,  SRC_DT,   1'b0, SH_NONE, BASE_ZERO, DST_DT3, 1'b0);
            4'd2:  u = mk(OP_MUL, SRC_DT2,  SRC_DT2,  1'b0, SH_NONE, BASE_ZERO, DST_DT4, 1'b0);
            4'd3:  u = mk(OP_MUL, SRC_SIGA, SRC_SIGA, 1'b0, SH_NONE, BASE_ZERO, DST_QA,  1'b0);
            4'd4:  u = mk(OP_MUL, SRC_V,    SRC_DT,   1'b0, SH_16,   BASE_H,    DST_H,   1'b0);
            4'd5:  u = mk(OP_MUL, SRC_AZ,   SRC_DT2,  1'b0, SH_33,   BASE_H,    DST_H,   1'b0);
            4'd6:  u = mk(OP_MUL, SRC_AZ,   SRC_DT,   1'b0, SH_16,   BASE_V,    DST_V,   1'b0);
            4'd7:  u = mk(OP_MUL, SRC_C,    SRC_DT,   1'b0, SH_15,   BASE_P00,  DST_P00, 1'b0);
            4'd8:  u = mk(OP_MUL, SRC_P11,  SRC_DT2,  1'b0, SH_32,   BASE_P00,  DST_P00, 1'b0);
            4'd9:  u = mk(OP_MUL, SRC_QA,   SRC_DT4,  1'b0, SH_66,   BASE_P00,  DST_P00, 1'b0);
            4'd10: u = mk(OP_MUL, SRC_P11,  SRC_DT,   1'b0, SH_16,   BASE_C,    DST_C,   1'b0);
            4'd11: u = mk(OP_MUL, SRC_QA,   SRC_DT3,  1'b0, SH_49,   BASE_C,    DST_C,   1'b0);
            4'd12: u = mk(OP_MUL, SRC_QA,   SRC_DT2,  1'b0, SH_32,   BASE_P11,  DST_P11, 1'b1);
            default: u = mk(OP_MUL, SRC_QA, SRC_DT2,  1'b0, SH_32,   BASE_P11,  DST_P11, 1'b1);
         endcase
      end else begin
         unique case (pc)
            4'd0:  u = mk(OP_MUL, SRC_SIGL, SRC_SIGL, 1'b0, SH_NONE, BASE_P00,  DST_S,   1'b0);
            4'd1:  u = mk(OP_TEST, SRC_DT,  SRC_DT,   1'b0, SH_NONE, BASE_ZERO, DST_S,   1'b0);
            4'd2:  u = mk(OP_DIV_K0, SRC_DT, SRC_DT,  1'b0, SH_NONE, BASE_ZERO, DST_S,   1'b0);
            4'd3:  u = mk(OP_DIV_K1, SRC_DT, SRC_DT,  1'b0, SH_NONE, BASE_ZERO, DST_S,   1'b0);
            4'd4:  u = mk(OP_MUL, SRC_K0,   SRC_Y,    1'b0, SH_32,   BASE_H,    DST_H,   1'b0);
            4'd5:  u = mk(OP_MUL, SRC_K1,   SRC_Y,    1'b0, SH_32,   BASE_V,    DST_V,   1'b0);
            4'd6:  u = mk(OP_MUL, SRC_K0,   SRC_C,    1'b1, SH_32,   BASE_C,    DST_N01, 1'b0);
            4'd7:  u = mk(OP_MUL, SRC_K1,   SRC_P00,  1'b1, SH_32,   BASE_C,    DST_N10, 1'b0);
            4'd8:  u = mk(OP_MUL, SRC_K1,   SRC_C,    1'b1, SH_32,   BASE_P11,  DST_P11, 1'b0);
            4'd9:  u = mk(OP_MUL, SRC_K0,   SRC_P00,  1'b1, SH_32,   BASE_P00,  DST_P00, 1'b0);
            default: u = mk(OP_AVG, SRC_DT, SRC_DT,   1'b0, SH_NONE, BASE_ZERO, DST_C,   1'b1);
         endcase
      end
      return u;
   endfunction

endpackage

>>> rtl/kalt_mul.sv
`timescale 1ns / 1ps
module kalt_mul
   import kalt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mul_cmd_type              cmd,
   input  logic [TERM_W-1:0]        a_mag,
   input  logic [TERM_W-1:0]        b_mag,
   output logic                     done,
   output logic signed [TERM_W-1:0] term
);

   logic [TERM_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic                     neg_ff, neg_in;
   shift_type                shift_ff, shift_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [1:0]               cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic signed [TERM_W-1:0] term_ff, term_in;

   logic [TERM_W/2-1:0] a_half, b_half;
   logic [TERM_W-1:0]   pp;
   logic [6:0]          shamt;
   logic [PROD_W-1:0]   shr;
   logic                half;
   logic [TERM_W:0]     qsum;
   logic [TERM_W-1:0]   lim, qmag;
   logic                over;

   always_comb begin
      a_half = cnt_ff[1] ? a_ff[TERM_W-1:TERM_W/2] : a_ff[TERM_W/2-1:0];
      b_half = cnt_ff[0] ? b_ff[TERM_W-1:TERM_W/2] : b_ff[TERM_W/2-1:0];
      pp     = a_half * b_half;
      shamt  = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0], 5'b0};

      shr  = acc_ff;
      half = 1'b0;
      case (shift_ff)
         SH_15:   begin shr = acc_ff >> 15; half = acc_ff[14]; end
         SH_16:   begin shr = acc_ff >> 16; half = acc_ff[15]; end
         SH_32:   begin shr = acc_ff >> 32; half = acc_ff[31]; end
         SH_33:   begin shr = acc_ff >> 33; half = acc_ff[32]; end
         SH_49:   begin shr = acc_ff >> 49; half = acc_ff[48]; end
         SH_66:   begin shr = acc_ff >> 66; half = acc_ff[65]; end
         default: begin shr = acc_ff; half = 1'b0; end
      endcase
      qsum = {1'b0, shr[TERM_W-1:0]} + (TERM_W+1)'(half);
      lim  = neg_ff ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
      over = (|shr[PROD_W-1:TERM_W]) | qsum[TERM_W] | (qsum[TERM_W-1:0] > lim);
      qmag = over ? lim : qsum[TERM_W-1:0];

      a_in     = a_ff;
      b_in     = b_ff;
      neg_in   = neg_ff;
      shift_in = shift_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      fin_in   = 1'b0;
      done_in  = fin_ff;
      term_in  = term_ff;

      if (cmd.start) begin
         a_in     = a_mag;
         b_in     = b_mag;
         neg_in   = cmd.neg;
         shift_in = cmd.shift;
         acc_in   = '0;
         cnt_in   = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + ({{(PROD_W-TERM_W){1'b0}}, pp} << shamt);
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         if (shift_ff == SH_NONE) begin
            term_in = shr[TERM_W-1:0];
         end else begin
            term_in = neg_ff ? -qmag : qmag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff     <= a_in;
      b_ff     <= b_in;
      neg_ff   <= neg_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
      term_ff  <= term_in;
   end

   assign done = done_ff;
   assign term = term_ff;

endmodule

>>> rtl/kalt_div.sv
`timescale 1ns / 1ps
module kalt_div
   import kalt_pkg::*;
#(
   parameter int COV_WIDTH = COV_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [COV_WIDTH-1:0] num,
   input  logic signed [COV_WIDTH-1:0] den,
   output logic                        done,
   output logic signed [COV_WIDTH-1:0] quot
);

   localparam int DW    = COV_WIDTH + 32;
   localparam int CNT_W = $clog2(DW + 1);

   logic [DW-1:0]               num_ff, num_in, q_ff, q_in;
   logic [COV_WIDTH-1:0]        md_ff, md_in;
   logic [COV_WIDTH:0]          rem_ff, rem_in;
   logic                        neg_ff, neg_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, fin_ff, fin_in, done_ff, done_in;
   logic signed [COV_WIDTH-1:0] quot_ff, quot_in;

   logic [COV_WIDTH-1:0] num_mag, den_mag;
   logic [COV_WIDTH:0]   rem_sh;
   logic                 ge, rnd;
   logic [DW:0]          qr, lim, qm;

   always_comb begin
      num_mag = num[COV_WIDTH-1] ? COV_WIDTH'(-num) : COV_WIDTH'(num);
      den_mag = den[COV_WIDTH-1] ? COV_WIDTH'(-den) : COV_WIDTH'(den);
      rem_sh  = {rem_ff[COV_WIDTH-1:0], num_ff[DW-1]};
      ge      = rem_sh >= {1'b0, md_ff};
      rnd     = {rem_ff, 1'b0} >= {2'b0, md_ff};
      qr      = {1'b0, q_ff} + (DW+1)'(rnd);
      lim     = neg_ff ? ((DW+1)'(1) << (COV_WIDTH-1))
                       : ((DW+1)'(1) << (COV_WIDTH-1)) - (DW+1)'(1);
      qm      = (qr > lim) ? lim : qr;

      num_in  = num_ff;
      q_in    = q_ff;
      md_in   = md_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = fin_ff;
      quot_in = quot_ff;

      if (start) begin
         num_in  = {num_mag, 32'b0};
         md_in   = den_mag;
         rem_in  = '0;
         q_in    = '0;
         neg_in  = num[COV_WIDTH-1] ^ den[COV_WIDTH-1];
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, md_ff} : rem_sh;
         q_in   = {q_ff[DW-2:0], ge};
         num_in = num_ff << 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end

      if (fin_ff) begin
         quot_in = neg_ff ? -qm[COV_WIDTH-1:0] : qm[COV_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      q_ff    <= q_in;
      md_ff   <= md_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

>>> rtl/kalman_altitude_2state_core.sv
// A predict request runs 13 products on the shared 32x32 multiplier, then loads the
// response registers; an update runs two radix-2 gain divisions of COV_WIDTH+32 steps
// each.
// One request at a time; req_ready is high only while idle.
// Reset (synchronous, active high) restores control state, estimates, covariance and CSRs.
`timescale 1ns / 1ps
module kalman_altitude_2state_core
   import kalt_pkg::*;
#(
   parameter int STATE_WIDTH = STATE_WIDTH_DEF,
   parameter int COV_WIDTH   = COV_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_mode,
   input  logic signed [ACCEL_W-1:0]  req_vertical_accel,
   input  logic [DIST_W-1:0]          req_lidar_distance,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_W-1:0]    rsp_height,
   output logic signed [OUT_W-1:0]    rsp_climb_rate,
   output logic [OUT_VAR_W-1:0]       rsp_height_variance,
   output logic                       rsp_update_skipped,
   input  logic                       csr_we,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [SIGMA_W-1:0]         csr_wdata
);

   localparam int Y_W   = (STATE_WIDTH > DIST_W + 1 ? STATE_WIDTH : DIST_W + 1) + 1;
   localparam int EXT_W = TERM_W + 2;

   localparam logic signed [EXT_W-1:0] ST_MAX  = (EXT_W'(1) <<< (STATE_WIDTH-1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] ST_MIN  = -ST_MAX - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] CV_MAX  = (EXT_W'(1) <<< (COV_WIDTH-1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] CV_MIN  = -CV_MAX - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] OUT_MAX = (EXT_W'(1) <<< (OUT_W-1)) - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] OUT_MIN = -OUT_MAX - EXT_W'(1);
   localparam logic signed [EXT_W-1:0] VAR_MAX = (EXT_W'(1) <<< OUT_VAR_W) - EXT_W'(1);

   localparam logic signed [COV_WIDTH-1:0] P00_RST = COV_WIDTH'(10) <<< 32;
   localparam logic signed [COV_WIDTH-1:0] P11_RST = COV_WIDTH'(1) <<< 32;

   state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;

   logic [DT_W-1:0]    dt_ff, dt_in;
   logic [SIGMA_W-1:0] siga_ff, siga_in, sigl_ff, sigl_in;

   logic signed [STATE_WIDTH-1:0] h_ff, h_in, v_ff, v_in;
   logic signed [COV_WIDTH-1:0]   p00_ff, p00_in, c_ff, c_in, p11_ff, p11_in;
   logic signed [COV_WIDTH-1:0]   s_ff, s_in, k0_ff, k0_in, k1_ff, k1_in;
   logic signed [COV_WIDTH-1:0]   n01_ff, n01_in, n10_ff, n10_in;
   logic [TERM_W-1:0]             dt2_ff, dt2_in, dt3_ff, dt3_in, dt4_ff, dt4_in;
   logic [TERM_W-1:0]             qa_ff, qa_in;
   logic signed [Y_W-1:0]         y_ff, y_in;
   logic signed [ACCEL_W-1:0]     az_ff, az_in;
   logic                          mode_ff, mode_in, skip_ff, skip_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]    height_ff, height_in, climb_ff, climb_in;
   logic [OUT_VAR_W-1:0]       var_ff, var_in;
   logic                       skipped_ff, skipped_in;

   uop_type     uop;
   mul_cmd_type mul_cmd;
   logic [TERM_W:0]          a_val, b_val;
   logic [TERM_W-1:0]        a_mag, b_mag;
   logic                     mul_done, div_start, div_done;
   logic signed [TERM_W-1:0] mul_term;
   logic signed [COV_WIDTH-1:0] div_num, div_quot;
   logic signed [EXT_W-1:0]  base_val, sum, st_sat, cv_sat, h_ext, v_ext, p_ext;
   logic signed [COV_WIDTH:0] avg_sum;
   logic                      load_rsp;

   function automatic logic [TERM_W:0] pick(src_type sel,
      logic [DT_W-1:0] dt, logic [TERM_W-1:0] dt2, logic [TERM_W-1:0] dt3,
      logic [TERM_W-1:0] dt4, logic [TERM_W-1:0] qa, logic [SIGMA_W-1:0] siga,
      logic [SIGMA_W-1:0] sigl, logic signed [STATE_WIDTH-1:0] v,
      logic signed [ACCEL_W-1:0] az, logic signed [COV_WIDTH-1:0] c,
      logic signed [COV_WIDTH-1:0] p11, logic signed [COV_WIDTH-1:0] p00,
      logic signed [COV_WIDTH-1:0] k0, logic signed [COV_WIDTH-1:0] k1,
      logic signed [Y_W-1:0] y);
      logic [TERM_W:0] r;
      case (sel)
         SRC_DT:   r = {1'b0, TERM_W'(dt)};
         SRC_DT2:  r = {1'b0, dt2};
         SRC_DT3:  r = {1'b0, dt3};
         SRC_DT4:  r = {1'b0, dt4};
         SRC_QA:   r = {1'b0, qa};
         SRC_SIGA: r = {1'b0, TERM_W'(siga)};
         SRC_SIGL: r = {1'b0, TERM_W'(sigl)};
         SRC_V:    r = (TERM_W+1)'(v);
         SRC_AZ:   r = (TERM_W+1)'(az);
         SRC_C:    r = (TERM_W+1)'(c);
         SRC_P11:  r = (TERM_W+1)'(p11);
         SRC_P00:  r = (TERM_W+1)'(p00);
         SRC_K0:   r = (TERM_W+1)'(k0);
         SRC_K1:   r = (TERM_W+1)'(k1);
         SRC_Y:    r = (TERM_W+1)'(y);
         default:  r = '0;
      endcase
      return r;
   endfunction

   assign uop = fetch_uop(mode_ff, pc_ff);

   always_comb begin
      a_val = pick(uop.a, dt_ff, dt2_ff, dt3_ff, dt4_ff, qa_ff, siga_ff, sigl_ff, v_ff,
                   az_ff, c_ff, p11_ff, p00_ff, k0_ff, k1_ff, y_ff);
      b_val = pick(uop.b, dt_ff, dt2_ff, dt3_ff, dt4_ff, qa_ff, siga_ff, sigl_ff, v_ff,
                   az_ff, c_ff, p11_ff, p00_ff, k0_ff, k1_ff, y_ff);
      a_mag = a_val[TERM_W] ? TERM_W'(-a_val) : a_val[TERM_W-1:0];
      b_mag = b_val[TERM_W] ? TERM_W'(-b_val) : b_val[TERM_W-1:0];
      mul_cmd.start = (state_ff == ST_ISSUE) && (uop.kind == OP_MUL);
      mul_cmd.neg   = a_val[TERM_W] ^ b_val[TERM_W] ^ uop.inv;
      mul_cmd.shift = uop.shift;
      div_start = (state_ff == ST_ISSUE)
                  && ((uop.kind == OP_DIV_K0) || (uop.kind == OP_DIV_K1));
      div_num   = (uop.kind == OP_DIV_K0) ? p00_ff : c_ff;
   end

   kalt_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a_mag (a_mag),
      .b_mag (b_mag),
      .done  (mul_done),
      .term  (mul_term)
   );

   kalt_div #(
      .COV_WIDTH (COV_WIDTH)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      case (uop.base)
         BASE_H:   base_val = EXT_W'(h_ff);
         BASE_V:   base_val = EXT_W'(v_ff);
         BASE_P00: base_val = EXT_W'(p00_ff);
         BASE_C:   base_val = EXT_W'(c_ff);
         BASE_P11: base_val = EXT_W'(p11_ff);
         default:  base_val = '0;
      endcase
      sum    = base_val + EXT_W'(mul_term);
      st_sat = (sum > ST_MAX) ? ST_MAX : ((sum < ST_MIN) ? ST_MIN : sum);
      cv_sat = (sum > CV_MAX) ? CV_MAX : ((sum < CV_MIN) ? CV_MIN : sum);
      avg_sum = (COV_WIDTH+1)'(n01_ff) + (COV_WIDTH+1)'(n10_ff);

      h_ext = EXT_W'(h_ff);
      v_ext = EXT_W'(v_ff);
      p_ext = EXT_W'(p00_ff);
   end

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      dt_in    = dt_ff;
      siga_in  = siga_ff;
      sigl_in  = sigl_ff;
      h_in     = h_ff;
      v_in     = v_ff;
      p00_in   = p00_ff;
      c_in     = c_ff;
      p11_in   = p11_ff;
      s_in     = s_ff;
      k0_in    = k0_ff;
      k1_in    = k1_ff;
      n01_in   = n01_ff;
      n10_in   = n10_ff;
      dt2_in   = dt2_ff;
      dt3_in   = dt3_ff;
      dt4_in   = dt4_ff;
      qa_in    = qa_ff;
      y_in     = y_ff;
      az_in    = az_ff;
      mode_in  = mode_ff;
      skip_in  = skip_ff;
      req_ready = (state_ff == ST_IDLE);

      if (csr_we) begin
         if (csr_index == CSR_SAMPLE_PERIOD) begin
            dt_in = csr_wdata[DT_W-1:0];
         end else if (csr_index == CSR_ACCEL_SIGMA) begin
            siga_in = csr_wdata;
         end else if (csr_index == CSR_LIDAR_SIGMA) begin
            sigl_in = csr_wdata;
         end
      end

      load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               az_in    = req_vertical_accel;
               y_in     = Y_W'(signed'({1'b0, req_lidar_distance})) - Y_W'(h_ff);
               skip_in  = 1'b0;
               pc_in    = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            unique case (uop.kind)
               OP_MUL: state_in = ST_MUL;
               OP_DIV_K0, OP_DIV_K1: state_in = ST_DIV;
               OP_TEST: begin
                  if (s_ff == '0) begin
                     skip_in  = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     pc_in = pc_ff + PC_W'(1);
                  end
               end
               OP_AVG: begin
                  c_in     = COV_WIDTH'(avg_sum >>> 1);
                  state_in = ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_MUL: begin
            if (mul_done) begin
               unique case (uop.dst)
                  DST_DT2: dt2_in = mul_term;
                  DST_DT3: dt3_in = mul_term;
                  DST_DT4: dt4_in = mul_term;
                  DST_QA:  qa_in  = mul_term;
                  DST_H:   h_in   = STATE_WIDTH'(st_sat);
                  DST_V:   v_in   = STATE_WIDTH'(st_sat);
                  DST_P00: p00_in = COV_WIDTH'(cv_sat);
                  DST_C:   c_in   = COV_WIDTH'(cv_sat);
                  DST_P11: p11_in = COV_WIDTH'(cv_sat);
                  DST_S:   s_in   = COV_WIDTH'(cv_sat);
                  DST_N01: n01_in = COV_WIDTH'(cv_sat);
                  DST_N10: n10_in = COV_WIDTH'(cv_sat);
                  default: s_in   = s_ff;
               endcase
               pc_in    = pc_ff + PC_W'(1);
               state_in = uop.last ? ST_DONE : ST_ISSUE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (uop.kind == OP_DIV_K0) begin
                  k0_in = div_quot;
               end else begin
                  k1_in = div_quot;
               end
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_ISSUE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      height_in  = height_ff;
      climb_in   = climb_ff;
      var_in     = var_ff;
      skipped_in = skipped_ff;
      if (load_rsp) begin
         height_in  = OUT_W'((h_ext > OUT_MAX) ? OUT_MAX : ((h_ext < OUT_MIN) ? OUT_MIN : h_ext));
         climb_in   = OUT_W'((v_ext > OUT_MAX) ? OUT_MAX : ((v_ext < OUT_MIN) ? OUT_MIN : v_ext));
         var_in     = (p_ext < 0) ? '0 : OUT_VAR_W'((p_ext > VAR_MAX) ? VAR_MAX : p_ext);
         skipped_in = skip_ff;
      end
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         dt_ff        <= DT_RST;
         siga_ff      <= SIGA_RST;
         sigl_ff      <= SIGL_RST;
         h_ff         <= '0;
         v_ff         <= '0;
         p00_ff       <= P00_RST;
         c_ff         <= '0;
         p11_ff       <= P11_RST;
         skip_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         dt_ff        <= dt_in;
         siga_ff      <= siga_in;
         sigl_ff      <= sigl_in;
         h_ff         <= h_in;
         v_ff         <= v_in;
         p00_ff       <= p00_in;
         c_ff         <= c_in;
         p11_ff       <= p11_in;
         skip_ff      <= skip_in;
      end
      s_ff       <= s_in;
      k0_ff      <= k0_in;
      k1_ff      <= k1_in;
      n01_ff     <= n01_in;
      n10_ff     <= n10_in;
      dt2_ff     <= dt2_in;
      dt3_ff     <= dt3_in;
      dt4_ff     <= dt4_in;
      qa_ff      <= qa_in;
      y_ff       <= y_in;
      az_ff      <= az_in;
      mode_ff    <= mode_in;
      height_ff  <= height_in;
      climb_ff   <= climb_in;
      var_ff     <= var_in;
      skipped_ff <= skipped_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_height          = height_ff;
   assign rsp_climb_rate      = climb_ff;
   assign rsp_height_variance = var_ff;
   assign rsp_update_skipped  = skipped_ff;

endmodule

>>> sim/tb_kalman_altitude_2state_core.sv
`timescale 1ns / 1ps
module tb_kalman_altitude_2state_core;
   import kalt_pkg::*;

   localparam logic MODE_PREDICT = 1'b0;
   localparam logic MODE_UPDATE  = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 78;

   typedef logic signed [65:0] wide_type;

   typedef struct {
      logic [OUT_W-1:0]     height;
      logic [OUT_W-1:0]     climb_rate;
      logic [OUT_VAR_W-1:0] height_variance;
      logic                 update_skipped;
   } estimate_type;

   class altitude_scoreboard;
      wide_type h, v, p00, c, p11;
      logic [DT_W-1:0]    dt;
      logic [SIGMA_W-1:0] sig_accel, sig_lidar;
      estimate_type estimates_q[$];
      int errors;

      function new();
         h = 0;
         v = 0;
         p00 = wide_type'(10) <<< 32;
         c = 0;
         p11 = wide_type'(1) <<< 32;
         dt = DT_RST;
         sig_accel = SIGA_RST;
         sig_lidar = SIGL_RST;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [SIGMA_W-1:0] val);
         case (idx)
            CSR_SAMPLE_PERIOD: dt = val[DT_W-1:0];
            CSR_ACCEL_SIGMA:   sig_accel = val;
            CSR_LIDAR_SIGMA:   sig_lidar = val;
            default: ;
         endcase
      endfunction

      function wide_type sat(wide_type x, int w);
         wide_type hi, lo;
         hi = (wide_type'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         return x > hi ? hi : (x < lo ? lo : x);
      endfunction

      function logic [63:0] mag(wide_type x);
         wide_type a;
         a = x < 0 ? -x : x;
         return a[63:0];
      endfunction

      function wide_type mul_round(logic neg, logic [63:0] a, logic [63:0] b, int s);
         logic [127:0] p, q, lim;
         wide_type m;
         p = {64'b0, a} * {64'b0, b};
         q = (p >> s) + ((p >> (s - 1)) & 128'd1);
         lim = neg ? (128'd1 << 63) : (128'd1 << 63) - 128'd1;
         if (q > lim) q = lim;
         m = wide_type'({2'b00, q[63:0]});
         return neg ? -m : m;
      endfunction

      function wide_type gain(wide_type p, wide_type d);
         logic [127:0] num, den, q, rem, lim;
         logic neg;
         wide_type m;
         num = {64'b0, mag(p)} << 32;
         den = {64'b0, mag(d)};
         q = num / den;
         rem = num % den;
         if (rem >= den - rem) q = q + 128'd1;
         neg = (p < 0) != (d < 0);
         lim = neg ? (128'd1 << (COV_WIDTH_DEF - 1)) : (128'd1 << (COV_WIDTH_DEF - 1)) - 128'd1;
         if (q > lim) q = lim;
         m = wide_type'({2'b00, q[63:0]});
         return neg ? -m : m;
      endfunction

      function void note_request(logic mode, logic [ACCEL_W-1:0] accel,
                                 logic [DIST_W-1:0] lidar);
         wide_type az, s, k0, k1, y, n01, n10, np00, r;
         logic [63:0] d, d2, d3, d4, qa, rr;
         estimate_type e;
         e.update_skipped = 1'b0;
         if (mode == MODE_PREDICT) begin
            az = wide_type'($signed(accel));
            d = 64'(dt);
            d2 = d * d;
            d3 = d2 * d;
            d4 = d2 * d2;
            qa = 64'(sig_accel) * 64'(sig_accel);
            h = sat(sat(h + mul_round(v < 0, mag(v), d, 16), STATE_WIDTH_DEF)
                    + mul_round(az < 0, mag(az), d2, 33), STATE_WIDTH_DEF);
            v = sat(v + mul_round(az < 0, mag(az), d, 16), STATE_WIDTH_DEF);
            np00 = sat(p00 + mul_round(c < 0, mag(c), d, 15), COV_WIDTH_DEF);
            np00 = sat(np00 + mul_round(p11 < 0, mag(p11), d2, 32), COV_WIDTH_DEF);
            np00 = sat(np00 + mul_round(1'b0, qa, d4, 66), COV_WIDTH_DEF);
            c = sat(c + mul_round(p11 < 0, mag(p11), d, 16), COV_WIDTH_DEF);
            c = sat(c + mul_round(1'b0, qa, d3, 49), COV_WIDTH_DEF);
            p11 = sat(p11 + mul_round(1'b0, qa, d2, 32), COV_WIDTH_DEF);
            p00 = np00;
         end else begin
            rr = 64'(sig_lidar) * 64'(sig_lidar);
            r = wide_type'({2'b00, rr});
            s = sat(p00 + r, COV_WIDTH_DEF);
            if (s == 0) begin
               e.update_skipped = 1'b1;
            end else begin
               k0 = gain(p00, s);
               k1 = gain(c, s);
               y = wide_type'({35'b0, lidar}) - h;
               h = sat(h + mul_round((k0 < 0) != (y < 0), mag(k0), mag(y), 32),
                       STATE_WIDTH_DEF);
               v = sat(v + mul_round((k1 < 0) != (y < 0), mag(k1), mag(y), 32),
                       STATE_WIDTH_DEF);
               np00 = sat(p00 + mul_round((k0 < 0) == (p00 < 0), mag(k0), mag(p00), 32),
                          COV_WIDTH_DEF);
               n01 = sat(c + mul_round((k0 < 0) == (c < 0), mag(k0), mag(c), 32),
                         COV_WIDTH_DEF);
               n10 = sat(c + mul_round((k1 < 0) == (p00 < 0), mag(k1), mag(p00), 32),
                         COV_WIDTH_DEF);
               p11 = sat(p11 + mul_round((k1 < 0) == (c < 0), mag(k1), mag(c), 32),
                         COV_WIDTH_DEF);
               c = (n01 >>> 1) + (n10 >>> 1) + wide_type'(n01[0] & n10[0]);
               p00 = np00;
            end
         end
         e.height = h[OUT_W-1:0];
         e.climb_rate = v[OUT_W-1:0];
         e.height_variance = p00 < 0 ? '0 : p00[OUT_VAR_W-1:0];
         estimates_q.push_back(e);
      endfunction

      task report(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [OUT_W-1:0] height, logic [OUT_W-1:0] climb,
                        logic [OUT_VAR_W-1:0] hvar, logic skipped);
         estimate_type e;
         if (estimates_q.size() == 0) begin
            report("response with no request pending");
         end else begin
            e = estimates_q.pop_front();
            if (height !== e.height)
               report($sformatf("height %h, want %h", height, e.height));
            if (climb !== e.climb_rate)
               report($sformatf("climb_rate %h, want %h", climb, e.climb_rate));
            if (hvar !== e.height_variance)
               report($sformatf("height_variance %h, want %h", hvar, e.height_variance));
            if (skipped !== e.update_skipped)
               report($sformatf("update_skipped %b, want %b", skipped, e.update_skipped));
         end
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_mode;
   logic signed [ACCEL_W-1:0] req_vertical_accel;
   logic [DIST_W-1:0]         req_lidar_distance;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [OUT_W-1:0]   rsp_height;
   logic signed [OUT_W-1:0]   rsp_climb_rate;
   logic [OUT_VAR_W-1:0]      rsp_height_variance;
   logic                      rsp_update_skipped;
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [SIGMA_W-1:0]        csr_wdata;

   altitude_scoreboard sb = new();
   bit idle_on = 1'b1;
   int stall_left = 0;
   int quiet_cycles = 0;

   kalman_altitude_2state_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_height, rsp_climb_rate, rsp_height_variance, rsp_update_skipped);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
         end
      end
   end

   task send_request(logic mode, logic [ACCEL_W-1:0] accel, logic [DIST_W-1:0] lidar);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_mode = mode;
      req_vertical_accel = accel;
      req_lidar_distance = lidar;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, accel, lidar);
   endtask

   task drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.estimates_q.size() != 0) @(posedge clock);
      repeat (8) @(negedge clock);
   endtask

   task write_csr(logic [CSR_IDX_W-1:0] idx, logic [SIGMA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task random_request();
      logic [ACCEL_W-1:0] accel;
      logic [DIST_W-1:0] lidar;
      accel = $urandom_range(0, 3) == 0 ? $urandom() : ACCEL_W'($urandom_range(0, 2 ** 21) - 2 ** 20);
      lidar = $urandom_range(0, 3) == 0 ? DIST_W'($urandom()) : DIST_W'($urandom_range(0, 200 << 16));
      if ($urandom_range(0, 9) < 6)
         send_request(MODE_PREDICT, accel, DIST_W'($urandom()));
      else
         send_request(MODE_UPDATE, ACCEL_W'($urandom()), lidar);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = MODE_PREDICT;
      req_vertical_accel = '0;
      req_lidar_distance = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(MODE_PREDICT, 32'h0000_0000, 31'h0);
      send_request(MODE_PREDICT, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_request(MODE_PREDICT, 32'h8000_0000, 31'h0);
      send_request(MODE_UPDATE, 32'hFFFF_FFFF, 31'h0);
      send_request(MODE_UPDATE, 32'h0, 31'h7FFF_FFFF);
      send_request(MODE_UPDATE, 32'h0, 31'd655360);
      drain();
      write_csr(CSR_UNUSED_IDX, 23'h7FFFFF);
      write_csr(CSR_SAMPLE_PERIOD, 23'h7F0000);
      send_request(MODE_PREDICT, 32'h7FFF_FFFF, 31'h0);
      drain();
      write_csr(CSR_LIDAR_SIGMA, 23'd0);
      send_request(MODE_UPDATE, 32'h0, 31'd327680);
      send_request(MODE_UPDATE, 32'h0, 31'd327680);
      send_request(MODE_UPDATE, 32'h0, 31'h7FFF_FFFF);
      drain();
      write_csr(CSR_SAMPLE_PERIOD, 23'd65535);
      write_csr(CSR_ACCEL_SIGMA, 23'd4194304);
      write_csr(CSR_LIDAR_SIGMA, 23'd4194304);
      repeat (4) send_request(MODE_PREDICT, 32'h7FFF_FFFF, 31'h0);
      repeat (3) send_request(MODE_PREDICT, 32'h8000_0000, 31'h0);
      send_request(MODE_UPDATE, 32'h0, 31'h0);
      send_request(MODE_UPDATE, 32'h0, 31'h7FFF_FFFF);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == PHASES - 1) idle_on = 1'b0;
         case (ph)
            0: begin
               write_csr(CSR_SAMPLE_PERIOD, DT_RST);
               write_csr(CSR_ACCEL_SIGMA, SIGA_RST);
               write_csr(CSR_LIDAR_SIGMA, SIGL_RST);
            end
            1: begin
               write_csr(CSR_SAMPLE_PERIOD, 23'd65535);
               write_csr(CSR_ACCEL_SIGMA, 23'd4194304);
               write_csr(CSR_LIDAR_SIGMA, 23'd4194304);
            end
            2: begin
               write_csr(CSR_SAMPLE_PERIOD, 23'd1);
               write_csr(CSR_ACCEL_SIGMA, 23'd0);
               write_csr(CSR_LIDAR_SIGMA, 23'd0);
            end
            default: begin
               write_csr(CSR_SAMPLE_PERIOD, SIGMA_W'($urandom_range(1, 65535)));
               write_csr(CSR_ACCEL_SIGMA, SIGMA_W'($urandom_range(0, 4194304)));
               write_csr(CSR_LIDAR_SIGMA, SIGMA_W'($urandom_range(0, 4194304)));
            end
         endcase
         repeat (PHASE_ITEMS) random_request();
         drain();
      end

      repeat (300) @(posedge clock);
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> kalman_altitude_2state_core.f
rtl/kalt_pkg.sv
rtl/kalt_mul.sv
rtl/kalt_div.sv
rtl/kalman_altitude_2state_core.sv
sim/tb_kalman_altitude_2state_core.sv
